FILE: sv/rc4_pkg.sv
// rc4_pkg: shared command encoding for the rc4 stream cipher
// holds the command opcode enum and the front-to-back command struct
// no dependencies
`timescale 1ns / 1ps

package rc4_pkg;

	// size of the permutation table, fixed by the cipher
	localparam int PERM_DEPTH = 256;

	// opcode field of an input transaction
	localparam logic OPC_KEY  = 1'b0;
	localparam logic OPC_DATA = 1'b1;

	typedef logic [7:0] byte_t;

	// classified command kinds passed from the front to the back
	typedef enum logic [1:0] {
		OP_KEY      = 2'd0,
		OP_KEY_LAST = 2'd1,
		OP_DATA     = 2'd2
	} op_t;

	typedef struct packed {
		op_t   op;
		byte_t value;
	} cmd_t;

endpackage

FILE: sv/rc4_if.sv
// rc4 channel interfaces: input item channel and result channel
// valid/ready handshake, payload travels with valid
// no dependencies
`timescale 1ns / 1ps

interface rc4_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] byte_value;
	logic       last_key;

	modport source (output valid, output opcode, output byte_value, output last_key,
		input ready);
	modport sink (input valid, input opcode, input byte_value, input last_key,
		output ready);
endinterface

interface rc4_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       no_key;

	modport source (output valid, output out_byte, output no_key, input ready);
	modport sink (input valid, input out_byte, input no_key, output ready);
endinterface

FILE: sv/rc4_front.sv
// rc4_front: accepts input transactions and classifies them into commands
// one register stage between the input channel and the command queue
// depends on rc4_pkg and rc4_if
`timescale 1ns / 1ps

module rc4_front (
	input  logic          clk,
	input  logic          arst_n,
	rc4_in_if.sink        item,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output rc4_pkg::cmd_t cmd
);

	logic          vld_q;
	rc4_pkg::cmd_t cmd_q;
	rc4_pkg::cmd_t cmd_new;

	assign item.ready = !vld_q || cmd_ready;

	always_comb begin
		cmd_new.value = item.byte_value;
		if (item.opcode == rc4_pkg::OPC_DATA) begin
			// last_key has no meaning on a data transaction
			cmd_new.op = rc4_pkg::OP_DATA;
		end else if (item.last_key) begin
			cmd_new.op = rc4_pkg::OP_KEY_LAST;
		end else begin
			cmd_new.op = rc4_pkg::OP_KEY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (item.ready) begin
			vld_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_q <= cmd_new;
		end
	end

	assign cmd_valid = vld_q;
	assign cmd       = cmd_q;

endmodule

FILE: sv/rc4_queue.sv
// rc4_queue: two-entry command queue between front and back
// lets each side stall independently
// depends on rc4_pkg
`timescale 1ns / 1ps

module rc4_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rc4_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output rc4_pkg::cmd_t out_cmd
);

	rc4_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

FILE: sv/rc4_back.sv
// rc4_back: key store, permutation table, key schedule and keystream generator
// sequencer over a single-write permutation memory, output register at the end
// depends on rc4_pkg and rc4_if
`timescale 1ns / 1ps

module rc4_back #(
	parameter int KEY_MAX_BYTES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  rc4_pkg::cmd_t cmd,
	rc4_out_if.source     result
);

	localparam int KAW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
	localparam int KCW = $clog2(KEY_MAX_BYTES + 1);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_FILL = 9'b000000010,
		ST_K1   = 9'b000000100,
		ST_K2   = 9'b000001000,
		ST_K3   = 9'b000010000,
		ST_K4   = 9'b000100000,
		ST_P2   = 9'b001000000,
		ST_P3   = 9'b010000000,
		ST_P4   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// permutation memory
	logic [7:0] perm_mem [rc4_pkg::PERM_DEPTH];
	logic [7:0] perm_rd_addr;
	logic [7:0] perm_rdata_q;
	logic       perm_we;
	logic [7:0] perm_wr_addr;
	logic [7:0] perm_wdata;

	// key memory
	logic [7:0]     key_mem [KEY_MAX_BYTES];
	logic [7:0]     key_rdata_q;
	logic           key_we;
	logic [KCW-1:0] key_count_q;
	logic [KCW-1:0] key_len_q;
	logic [KAW-1:0] key_idx_q;
	logic           key_room;
	logic           key_wrap;
	logic           key_ready_q;

	// schedule and generator state
	logic [7:0] pos_q;
	logic [7:0] acc_q;
	logic [7:0] swap_q;
	logic [7:0] sj_q;
	logic [7:0] idx_i_q;
	logic [7:0] idx_j_q;
	logic [7:0] t_q;
	logic       hit_i_q;
	logic       hit_j_q;
	logic [7:0] data_q;

	logic [7:0] acc_sum;
	logic [7:0] j_sum;
	logic [7:0] t_sum;
	logic [7:0] ks;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       no_key_q;
	logic       out_free;
	logic       out_load;
	logic [7:0] out_byte_d;
	logic       no_key_d;

	assign out_free = !out_valid_q || result.ready;
	assign key_room = (key_count_q != KCW'(KEY_MAX_BYTES));
	assign key_wrap = ((KCW'(key_idx_q) + KCW'(1)) == key_len_q);

	assign acc_sum = acc_q + perm_rdata_q + key_rdata_q;
	assign j_sum   = idx_j_q + perm_rdata_q;
	assign t_sum   = swap_q + perm_rdata_q;
	// the table read for the keystream was issued before the swap landed
	assign ks      = hit_j_q ? swap_q : (hit_i_q ? sj_q : perm_rdata_q);

	always_comb begin
		state_d      = state_q;
		cmd_ready    = 1'b0;
		perm_rd_addr = pos_q;
		perm_we      = 1'b0;
		perm_wr_addr = pos_q;
		perm_wdata   = perm_rdata_q;
		key_we       = 1'b0;
		out_load     = 1'b0;
		out_byte_d   = 8'd0;
		no_key_d     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						rc4_pkg::OP_KEY: begin
							cmd_ready = 1'b1;
							key_we    = key_room;
						end
						rc4_pkg::OP_KEY_LAST: begin
							cmd_ready = 1'b1;
							key_we    = key_room;
							state_d   = ST_FILL;
						end
						rc4_pkg::OP_DATA: begin
							if (!key_ready_q) begin
								if (out_free) begin
									cmd_ready = 1'b1;
									out_load  = 1'b1;
									no_key_d  = 1'b1;
								end
							end else begin
								cmd_ready    = 1'b1;
								perm_rd_addr = idx_i_q + 8'd1;
								state_d      = ST_P2;
							end
						end
						default: begin
							cmd_ready = 1'b1;
						end
					endcase
				end
			end
			ST_FILL: begin
				perm_we      = 1'b1;
				perm_wr_addr = pos_q;
				perm_wdata   = pos_q;
				if (pos_q == 8'hFF) begin
					state_d = ST_K1;
				end
			end
			ST_K1: begin
				perm_rd_addr = pos_q;
				state_d      = ST_K2;
			end
			ST_K2: begin
				perm_rd_addr = acc_sum;
				state_d      = ST_K3;
			end
			ST_K3: begin
				perm_we      = 1'b1;
				perm_wr_addr = pos_q;
				perm_wdata   = perm_rdata_q;
				state_d      = ST_K4;
			end
			ST_K4: begin
				perm_we      = 1'b1;
				perm_wr_addr = acc_q;
				perm_wdata   = swap_q;
				state_d      = (pos_q == 8'hFF) ? ST_IDLE : ST_K1;
			end
			ST_P2: begin
				perm_rd_addr = j_sum;
				state_d      = ST_P3;
			end
			ST_P3: begin
				perm_we      = 1'b1;
				perm_wr_addr = idx_i_q;
				perm_wdata   = perm_rdata_q;
				perm_rd_addr = t_sum;
				state_d      = ST_P4;
			end
			ST_P4: begin
				// rewrites the same entry while the output register is full
				perm_we      = 1'b1;
				perm_wr_addr = idx_j_q;
				perm_wdata   = swap_q;
				perm_rd_addr = t_q;
				if (out_free) begin
					out_load   = 1'b1;
					out_byte_d = data_q ^ ks;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= '0;
			key_ready_q <= 1'b0;
			idx_i_q     <= 8'd0;
			idx_j_q     <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && cmd_valid && cmd_ready) begin
				if (cmd.op == rc4_pkg::OP_KEY && key_room) begin
					key_count_q <= key_count_q + KCW'(1);
				end else if (cmd.op == rc4_pkg::OP_KEY_LAST) begin
					key_count_q <= '0;
				end
			end
			if (state_q == ST_K4 && pos_q == 8'hFF) begin
				idx_i_q     <= 8'd0;
				idx_j_q     <= 8'd0;
				key_ready_q <= 1'b1;
			end
			if (state_q == ST_P2) begin
				idx_i_q <= idx_i_q + 8'd1;
				idx_j_q <= j_sum;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd_ready) begin
					data_q <= cmd.value;
					if (cmd.op == rc4_pkg::OP_KEY_LAST) begin
						key_len_q <= key_room ? (key_count_q + KCW'(1)) : key_count_q;
						pos_q     <= 8'd0;
					end
				end
			end
			ST_FILL: begin
				pos_q     <= pos_q + 8'd1;
				acc_q     <= 8'd0;
				key_idx_q <= '0;
			end
			ST_K2: begin
				acc_q  <= acc_sum;
				swap_q <= perm_rdata_q;
			end
			ST_K4: begin
				pos_q     <= pos_q + 8'd1;
				key_idx_q <= key_wrap ? '0 : (key_idx_q + KAW'(1));
			end
			ST_P2: begin
				swap_q <= perm_rdata_q;
			end
			ST_P3: begin
				sj_q    <= perm_rdata_q;
				t_q     <= t_sum;
				hit_i_q <= (t_sum == idx_i_q);
				hit_j_q <= (t_sum == idx_j_q);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_byte_q <= out_byte_d;
			no_key_q   <= no_key_d;
		end
	end

	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_wr_addr] <= perm_wdata;
		end
		perm_rdata_q <= perm_mem[perm_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_count_q[KAW-1:0]] <= cmd.value;
		end
		key_rdata_q <= key_mem[key_idx_q];
	end

	assign result.valid    = out_valid_q;
	assign result.out_byte = out_byte_q;
	assign result.no_key   = no_key_q;

endmodule

FILE: sv/rc4_stream_cipher.sv
// data byte: front register, queue, then back states idle, P2, P3 and P4 (three
// dependent permutation memory accesses); the next byte waits for idle again
// key byte: stored in idle; last key byte: fill pass over all 256 table entries,
// then a K1..K4 swap per entry, two writes each on the single-write memory
// reset clears control state only; the permutation table is rebuilt by each key
// schedule and is not read before the first one, so there is no clearing pass
`timescale 1ns / 1ps

// rc4_stream_cipher: top level, front classifier, command queue and back sequencer
// depends on rc4_pkg, rc4_if, rc4_front, rc4_queue, rc4_back

module rc4_stream_cipher #(
	parameter int KEY_MAX_BYTES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	rc4_in_if.sink    item,
	rc4_out_if.source result
);

	logic          front_valid;
	logic          front_ready;
	rc4_pkg::cmd_t front_cmd;
	logic          back_valid;
	logic          back_ready;
	rc4_pkg::cmd_t back_cmd;

	rc4_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	rc4_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_cmd    (front_cmd),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_cmd   (back_cmd)
	);

	rc4_back #(
		.KEY_MAX_BYTES (KEY_MAX_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.result    (result)
	);

endmodule

FILE: sv/rc4_checker.sv
// rc4_checker: port-level assertions for rc4_stream_cipher, attached by bind
// tracks outstanding data transactions against delivered results
// depends on rc4_pkg, rc4_stream_cipher and rc4_if
`timescale 1ns / 1ps

module rc4_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_opcode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       no_key
);

	logic [3:0] pend_q;
	logic       keyed_q;
	logic       data_in;
	logic       res_out;

	assign data_in = in_valid && in_ready && (in_opcode == rc4_pkg::OPC_DATA);
	assign res_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 4'd0;
			keyed_q <= 1'b0;
		end else begin
			if (data_in && !res_out) begin
				pend_q <= pend_q + 4'd1;
			end else if (res_out && !data_in) begin
				pend_q <= pend_q - 4'd1;
			end
			if (res_out && !no_key) begin
				keyed_q <= 1'b1;
			end
		end
	end

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(no_key))
		else $error("result changed while stalled");

	// every result answers an accepted data transaction
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("result without a pending data transaction");

	// a flagged result carries a zero byte
	a_no_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_key |-> out_byte == 8'd0)
		else $error("no_key result with nonzero byte");

	// once a keyed result has been seen, a key is always present
	a_key_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && keyed_q |-> !no_key)
		else $error("no_key after a key was scheduled");

endmodule

bind rc4_stream_cipher rc4_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_opcode (item.opcode),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_byte  (result.out_byte),
	.no_key    (result.no_key)
);

FILE: tb/rc4_stream_cipher_tb.sv
// rc4_stream_cipher_tb: self-checking bench for the rc4 stream cipher top level
// predicts results with its own rc4 key schedule and generator (fixed rows use table values), compares field by field
// depends on rc4_pkg, rc4_if and rc4_stream_cipher
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;

	localparam int KEY_LIMIT        = 256;
	localparam int N_DIR            = 23;
	localparam int N_RANDOM         = 1930;
	localparam int PAUSE_AT_A       = N_DIR;
	localparam int PAUSE_AT_B       = N_DIR + 900;
	localparam int LONG_HOLD_AT     = N_DIR + 400;
	localparam int LONG_HOLD_CYCLES = 2000;
	// a last key byte keeps the block busy through a full key schedule
	localparam int SETTLE_CYCLES    = 1500;

	typedef struct packed {
		logic           op;
		rc4_pkg::byte_t value;
		logic           last;
		logic           fixed;
		rc4_pkg::byte_t exp_byte;
		logic           exp_no_key;
	} stim_t;

	typedef struct packed {
		rc4_pkg::byte_t out_byte;
		logic           no_key;
	} result_t;

	logic clk;
	logic arst_n;

	rc4_in_if  item_ch ();
	rc4_out_if result_ch ();

	rc4_stream_cipher #(
		.KEY_MAX_BYTES(KEY_LIMIT)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	// cipher state kept by the bench
	rc4_pkg::byte_t perm_s [256];
	rc4_pkg::byte_t key_bytes [256];
	int             key_len;
	rc4_pkg::byte_t idx_i;
	rc4_pkg::byte_t idx_j;
	bit             keyed;

	stim_t   directed_tbl [N_DIR];
	stim_t   stim_q [$];
	result_t pending [$];

	int n_accepted;
	int n_errors;
	int n_schedules;
	int n_data;
	int n_no_key;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void run_key_schedule();
		int             len;
		rc4_pkg::byte_t acc;
		rc4_pkg::byte_t t;
		len = (key_len == 0) ? 1 : key_len;
		for (int p = 0; p < 256; p++)
			perm_s[p] = rc4_pkg::byte_t'(p);
		acc = 8'h00;
		for (int p = 0; p < 256; p++) begin
			acc = acc + perm_s[p] + key_bytes[p % len];
			t = perm_s[p];
			perm_s[p] = perm_s[acc];
			perm_s[acc] = t;
		end
		idx_i = 8'h00;
		idx_j = 8'h00;
		key_len = 0;
		keyed = 1'b1;
		n_schedules++;
	endfunction

	// returns 1 when the transaction produces a result
	function automatic bit cipher_item(input logic op, input rc4_pkg::byte_t v,
			input logic last, output result_t r);
		rc4_pkg::byte_t t;
		rc4_pkg::byte_t ks_idx;
		r = '0;
		if (op == rc4_pkg::OPC_KEY) begin
			// bytes past the limit are dropped, the count saturates
			if (key_len < KEY_LIMIT) begin
				key_bytes[key_len] = v;
				key_len++;
			end
			if (last)
				run_key_schedule();
			return 1'b0;
		end
		if (!keyed) begin
			r.no_key = 1'b1;
			return 1'b1;
		end
		idx_i = idx_i + 8'd1;
		idx_j = idx_j + perm_s[idx_i];
		t = perm_s[idx_i];
		perm_s[idx_i] = perm_s[idx_j];
		perm_s[idx_j] = t;
		ks_idx = perm_s[idx_i] + perm_s[idx_j];
		r.out_byte = v ^ perm_s[ks_idx];
		return 1'b1;
	endfunction

	function automatic void add_row(input logic op, input rc4_pkg::byte_t v, input logic last);
		stim_t row;
		row = '0;
		row.op = op;
		row.value = v;
		row.last = last;
		stim_q.push_back(row);
	endfunction

	// input side: predict on every accepted transaction
	always @(posedge clk) begin : track_items
		stim_t   row;
		result_t r;
		bit      has;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			row = stim_q[n_accepted];
			has = cipher_item(item_ch.opcode, item_ch.byte_value, item_ch.last_key, r);
			if (has) begin
				if (row.fixed) begin
					r.out_byte = row.exp_byte;
					r.no_key = row.exp_no_key;
				end
				pending.push_back(r);
			end
			n_accepted++;
		end
	end

	// output side: compare with the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result out_byte=%h no_key=%b", $time,
					result_ch.out_byte, result_ch.no_key);
			end else begin
				want = pending.pop_front();
				if (result_ch.out_byte !== want.out_byte) begin
					n_errors++;
					$display("%0t: out_byte mismatch expected %h actual %h", $time,
						want.out_byte, result_ch.out_byte);
				end
				if (result_ch.no_key !== want.no_key) begin
					n_errors++;
					$display("%0t: no_key mismatch expected %b actual %b", $time,
						want.no_key, result_ch.no_key);
				end
				n_data++;
				if (want.no_key)
					n_no_key++;
			end
		end
	end

	// receiver: rotating stall pattern plus one long hold-off
	initial begin : drive_ready
		int pat_cnt;
		int hold;
		bit held;
		bit rdy;
		pat_cnt = 0;
		held = 1'b0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && n_accepted >= LONG_HOLD_AT) begin
				held = 1'b1;
				hold = 0;
				result_ch.ready <= 1'b0;
				while (hold < LONG_HOLD_CYCLES) begin
					@(negedge clk);
					hold++;
				end
			end else begin
				pat_cnt++;
				case ((pat_cnt / 64) % 4)
					0: rdy = 1'b1;
					1: rdy = pat_cnt[0];
					2: rdy = ($urandom_range(0, 9) > 2);
					default: rdy = ((pat_cnt % 4) == 0);
				endcase
				result_ch.ready <= rdy;
			end
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : main
		int             burst_left;
		int             gap;
		bit             calm;
		int             n_rand;
		int             seg;
		int             klen;
		int             dlen;
		int             r;
		rc4_pkg::byte_t v;

		item_ch.valid = 1'b0;
		item_ch.opcode = rc4_pkg::OPC_KEY;
		item_ch.byte_value = 8'h00;
		item_ch.last_key = 1'b0;
		arst_n = 1'b0;
		n_accepted = 0;
		n_errors = 0;
		n_schedules = 0;
		n_data = 0;
		n_no_key = 0;
		for (int p = 0; p < 256; p++) begin
			perm_s[p] = rc4_pkg::byte_t'(p);
			key_bytes[p] = 8'h00;
		end
		key_len = 0;
		idx_i = 8'h00;
		idx_j = 8'h00;
		keyed = 1'b0;

		// op, value, last, fixed, exp_byte, exp_no_key
		directed_tbl = '{
			'{rc4_pkg::OPC_DATA, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1},  // data before any key
			'{rc4_pkg::OPC_DATA, 8'hff, 1'b1, 1'b1, 8'h00, 1'b1},
			'{rc4_pkg::OPC_KEY,  8'h4b, 1'b0, 1'b0, 8'h00, 1'b0},  // key "Key"
			'{rc4_pkg::OPC_KEY,  8'h65, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_KEY,  8'h79, 1'b1, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_DATA, 8'h50, 1'b0, 1'b0, 8'h00, 1'b0},  // "Plaintext"
			'{rc4_pkg::OPC_DATA, 8'h6c, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_DATA, 8'h61, 1'b0, 1'b0, 8'h00, 1'b0},
			// last_key on data is ignored
			'{rc4_pkg::OPC_DATA, 8'h69, 1'b1, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_DATA, 8'h6e, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_DATA, 8'h74, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_DATA, 8'h65, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_DATA, 8'h78, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_DATA, 8'h74, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_KEY,  8'hff, 1'b1, 1'b0, 8'h00, 1'b0},  // one-byte key
			'{rc4_pkg::OPC_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_DATA, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0},
			// new key loaded while in use
			'{rc4_pkg::OPC_KEY,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_KEY,  8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_DATA, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_DATA, 8'haa, 1'b0, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_KEY,  8'h01, 1'b1, 1'b0, 8'h00, 1'b0},
			'{rc4_pkg::OPC_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0}
		};
		foreach (directed_tbl[k])
			stim_q.push_back(directed_tbl[k]);

		// random part: key then a data burst, with stray key bytes and last_key noise
		n_rand = 0;
		seg = 0;
		while (n_rand < N_RANDOM) begin
			if (seg == 2)
				klen = 260;  // runs past the key limit
			else if (seg == 6)
				klen = 256;
			else if ($urandom_range(0, 3) == 0)
				klen = $urandom_range(1, 3);
			else
				klen = $urandom_range(1, 24);
			for (int k = 0; k < klen; k++)
				add_row(rc4_pkg::OPC_KEY, rc4_pkg::byte_t'($urandom_range(0, 255)),
					(k == klen - 1));
			n_rand += klen;
			dlen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(10, 90);
			for (int d = 0; d < dlen; d++) begin
				r = $urandom_range(0, 19);
				if ($urandom_range(0, 15) == 0)
					v = $urandom_range(0, 1) ? 8'hff : 8'h00;
				else
					v = rc4_pkg::byte_t'($urandom_range(0, 255));
				if (r == 0)
					add_row(rc4_pkg::OPC_KEY, v, 1'b0);
				else
					add_row(rc4_pkg::OPC_DATA, v, (r == 1));
			end
			n_rand += dlen;
			seg++;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		burst_left = 0;
		calm = 1'b0;
		for (int n = 0; n < stim_q.size(); n++) begin
			if (n == PAUSE_AT_A || n == PAUSE_AT_B) begin
				@(negedge clk);
				item_ch.valid <= 1'b0;
				while (pending.size() != 0)
					@(negedge clk);
			end else if (burst_left == 0) begin
				if ($urandom_range(0, 9) == 0)
					calm = !calm;
				burst_left = $urandom_range(1, 24);
				gap = calm ? 0 : $urandom_range(0, 8);
				repeat (gap) begin
					@(negedge clk);
					item_ch.valid <= 1'b0;
				end
			end
			@(negedge clk);
			item_ch.valid <= 1'b1;
			item_ch.opcode <= stim_q[n].op;
			item_ch.byte_value <= stim_q[n].value;
			item_ch.last_key <= stim_q[n].last;
			@(posedge clk);
			while (!item_ch.ready)
				@(posedge clk);
			if (burst_left > 0)
				burst_left--;
		end
		@(negedge clk);
		item_ch.valid <= 1'b0;

		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d transactions, %0d key schedules, %0d data results",
			n_accepted, n_schedules, n_data);
		$display("of which %0d were flagged as arriving before any key", n_no_key);
		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
sv/rc4_pkg.sv
sv/rc4_if.sv
sv/rc4_front.sv
sv/rc4_queue.sv
sv/rc4_back.sv
sv/rc4_stream_cipher.sv
sv/rc4_checker.sv
tb/rc4_stream_cipher_tb.sv
